// ===== design/cpd_pkg.sv =====
// Shared types, codes and the CRC-16/XMODEM byte update for the packet deframer.
`default_nettype none
package cpd_pkg;

  localparam int MAX_PAYLOAD_DEF = 32;
  localparam int LEN_W = 6;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_FAULT = 2'd1;
  localparam logic [1:0] KIND_FATAL = 2'd2;

  localparam logic [1:0] FAULT_MAGIC1 = 2'd0;
  localparam logic [1:0] FAULT_MAGIC2 = 2'd1;
  localparam logic [1:0] FAULT_LEN    = 2'd2;
  localparam logic [1:0] FAULT_CRC    = 2'd3;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       code;
    logic [7:0]       msg_id;
    logic [LEN_W-1:0] length;
  } cmd_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/cpd_front.sv =====
// Frame parser: walks the frame bytes, keeps the CRC and fault state, issues commands.
`default_nettype none
module cpd_front
  import cpd_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  parameter int AW = 5
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [7:0]    in_rx_byte,
  output logic               full,
  input  wire logic          cfg_valid,
  input  wire logic [7:0]    cfg_index,
  input  wire logic [7:0]    cfg_data,
  input  wire logic          q_full,
  input  wire logic          q_empty,
  output logic               q_push,
  output cmd_t               q_cmd,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [7:0]         wr_data
);

  localparam logic [2:0] PH_MAGIC1  = 3'd0;
  localparam logic [2:0] PH_MAGIC2  = 3'd1;
  localparam logic [2:0] PH_ID      = 3'd2;
  localparam logic [2:0] PH_LEN     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_CRC1    = 3'd5;
  localparam logic [2:0] PH_CRC2    = 3'd6;

  localparam logic [7:0] REG_MAGIC1  = 8'd0;
  localparam logic [7:0] REG_MAGIC2  = 8'd1;
  localparam logic [7:0] REG_MAXLEN  = 8'd2;
  localparam logic [7:0] REG_THRESH  = 8'd3;

  localparam logic [7:0] MAX_PAYLOAD_B = 8'(MAX_PAYLOAD);

  logic [7:0]       magic1_r, magic2_r, thresh_r;
  logic [LEN_W-1:0] max_len_r;

  logic [2:0]       phase_r, phase_nxt;
  logic [7:0]       id_r, id_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       crc_lo_r, crc_lo_nxt;
  logic [7:0]       cnt_r, cnt_nxt;
  logic             synced_r, synced_nxt;
  logic             halted_r, halted_nxt;

  logic             accept;
  logic             do_fault;
  logic [1:0]       fcode;
  logic [7:0]       cnt_inc;
  logic [LEN_W:0]   idx_inc;
  logic [15:0]      crc_upd;

  assign full    = !halted_r && (q_full || (phase_r == PH_PAYLOAD && !q_empty));
  assign accept  = push && !full;
  assign cnt_inc = (cnt_r == 8'hFF) ? cnt_r : cnt_r + 8'd1;
  assign idx_inc = {1'b0, idx_r} + {{LEN_W{1'b0}}, 1'b1};
  assign crc_upd = crc_byte(crc_r, in_rx_byte);
  assign wr_addr = idx_r[AW-1:0];
  assign wr_data = in_rx_byte;

  always_comb begin
    phase_nxt  = phase_r;
    id_nxt     = id_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    crc_nxt    = crc_r;
    crc_lo_nxt = crc_lo_r;
    cnt_nxt    = cnt_r;
    synced_nxt = synced_r;
    halted_nxt = halted_r;
    do_fault   = 1'b0;
    fcode      = FAULT_MAGIC1;
    q_push     = 1'b0;
    q_cmd      = '0;
    wr_en      = 1'b0;
    if (accept && !halted_r) begin
      unique case (phase_r)
        PH_MAGIC1: begin
          if (in_rx_byte == magic1_r) begin
            phase_nxt = PH_MAGIC2;
            crc_nxt   = crc_byte(16'h0000, in_rx_byte);
          end else begin
            do_fault = 1'b1;
            fcode    = FAULT_MAGIC1;
          end
        end
        PH_MAGIC2: begin
          if (in_rx_byte == magic2_r) begin
            phase_nxt = PH_ID;
            crc_nxt   = crc_upd;
          end else begin
            do_fault  = 1'b1;
            fcode     = FAULT_MAGIC2;
            phase_nxt = PH_MAGIC1;
          end
        end
        PH_ID: begin
          id_nxt    = in_rx_byte;
          crc_nxt   = crc_upd;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          idx_nxt = '0;
          if (in_rx_byte > {2'b00, max_len_r} || in_rx_byte > MAX_PAYLOAD_B) begin
            do_fault  = 1'b1;
            fcode     = FAULT_LEN;
            phase_nxt = PH_MAGIC1;
          end else begin
            len_nxt   = in_rx_byte[LEN_W-1:0];
            crc_nxt   = crc_upd;
            phase_nxt = (in_rx_byte != 8'd0) ? PH_PAYLOAD : PH_CRC1;
          end
        end
        PH_PAYLOAD: begin
          wr_en   = 1'b1;
          crc_nxt = crc_upd;
          idx_nxt = idx_inc[LEN_W-1:0];
          if (idx_inc >= {1'b0, len_r}) begin
            phase_nxt = PH_CRC1;
          end
        end
        PH_CRC1: begin
          crc_lo_nxt = in_rx_byte;
          phase_nxt  = PH_CRC2;
        end
        PH_CRC2: begin
          phase_nxt = PH_MAGIC1;
          if ({in_rx_byte, crc_lo_r} != crc_r) begin
            do_fault = 1'b1;
            fcode    = FAULT_CRC;
          end else begin
            cnt_nxt      = '0;
            synced_nxt   = 1'b1;
            q_push       = 1'b1;
            q_cmd.kind   = KIND_DATA;
            q_cmd.code   = FAULT_MAGIC1;
            q_cmd.msg_id = id_r;
            q_cmd.length = len_r;
          end
        end
        default: begin
          phase_nxt = PH_MAGIC1;
        end
      endcase
      if (do_fault && synced_r) begin
        cnt_nxt    = cnt_inc;
        q_push     = 1'b1;
        q_cmd.code = fcode;
        if (thresh_r != 8'd0 && cnt_inc >= thresh_r) begin
          halted_nxt = 1'b1;
          q_cmd.kind = KIND_FATAL;
        end else begin
          q_cmd.kind = KIND_FAULT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic1_r  <= 8'hAA;
      magic2_r  <= 8'h55;
      max_len_r <= LEN_W'(32);
      thresh_r  <= 8'd8;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MAGIC1: magic1_r  <= cfg_data;
        REG_MAGIC2: magic2_r  <= cfg_data;
        REG_MAXLEN: max_len_r <= cfg_data[LEN_W-1:0];
        REG_THRESH: thresh_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_MAGIC1;
      id_r     <= '0;
      len_r    <= '0;
      idx_r    <= '0;
      crc_r    <= '0;
      crc_lo_r <= '0;
      cnt_r    <= '0;
      synced_r <= 1'b0;
      halted_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      id_r     <= id_nxt;
      len_r    <= len_nxt;
      idx_r    <= idx_nxt;
      crc_r    <= crc_nxt;
      crc_lo_r <= crc_lo_nxt;
      cnt_r    <= cnt_nxt;
      synced_r <= synced_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/cpd_cmdq.sv =====
// Two-entry command queue between the frame parser and the result generator.
`default_nettype none
module cpd_cmdq
  import cpd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      din,
  input  wire logic pop,
  output cmd_t      dout,
  output logic      full,
  output logic      empty
);

  cmd_t       entry_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entry_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= !wp_r;
      end
      if (do_pop) begin
        rp_r <= !rp_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/cpd_back.sv =====
// Result generator: payload store and expansion of commands into result items.
`default_nettype none
module cpd_back
  import cpd_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  parameter int AW = 5
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cmd_valid,
  input  cmd_t                  cmd,
  output logic                  cmd_pop,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [7:0]       wr_data,
  input  wire logic             pop,
  output logic                  empty,
  output logic [1:0]            out_kind,
  output logic [7:0]            out_msg_id,
  output logic [LEN_W-1:0]      out_length,
  output logic [7:0]            out_data_byte,
  output logic                  out_has_data,
  output logic                  out_last,
  output logic [1:0]            out_fault_code
);

  logic [7:0]       store [MAX_PAYLOAD];
  logic             ov_r;
  logic [LEN_W-1:0] idx_r;
  logic [LEN_W:0]   idx_inc;
  logic             load;
  logic             has;
  logic             last;

  assign empty   = !ov_r;
  assign load    = cmd_valid && (!ov_r || pop);
  assign has     = (cmd.kind == KIND_DATA) && (cmd.length != '0);
  assign idx_inc = {1'b0, idx_r} + {{LEN_W{1'b0}}, 1'b1};
  assign last    = !has || (idx_inc == {1'b0, cmd.length});
  assign cmd_pop = load && last;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    if (load) begin
      out_data_byte <= has ? store[idx_r[AW-1:0]] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind       <= cmd.kind;
      out_msg_id     <= cmd.msg_id;
      out_length     <= cmd.length;
      out_has_data   <= has;
      out_last       <= last;
      out_fault_code <= cmd.code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      idx_r <= '0;
    end else begin
      if (load) begin
        ov_r  <= 1'b1;
        idx_r <= last ? '0 : idx_inc[LEN_W-1:0];
      end else if (pop) begin
        ov_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/crc_checked_packet_deframer.sv =====
// Top level of the CRC-checked packet deframer.
`default_nettype none
// Takes one link byte per cycle (push/full) and parses frames of two magic bytes, id,
// length, payload and a little-endian CRC-16/XMODEM. A frame parser classifies each byte
// in the cycle it is taken and hands good frames and synchronized faults to a two-entry
// command queue; the result generator turns each command into results (empty/pop), one
// per cycle while popped, from a single output register, reading payload bytes from a store of
// MAX_PAYLOAD bytes. A good frame of length n gives n results (one if n is 0), a fault one.
// Bytes are taken every cycle except while the queue is full, or while a new frame's
// payload would overwrite a store still being drained: then full stays high until every
// queued command, the previous frame's last payload result included, has been loaded
// into the output register. After a fatal result the block takes and drops all bytes
// until reset. Configuration writes are always ready.
module crc_checked_packet_deframer
  import cpd_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [7:0]       in_rx_byte,
  output logic                  empty,
  input  wire logic             pop,
  output logic [1:0]            out_kind,
  output logic [7:0]            out_msg_id,
  output logic [LEN_W-1:0]      out_length,
  output logic [7:0]            out_data_byte,
  output logic                  out_has_data,
  output logic                  out_last,
  output logic [1:0]            out_fault_code,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [7:0]       cfg_index,
  input  wire logic [7:0]       cfg_data
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic          q_full, q_empty, q_push, q_pop;
  cmd_t          q_din, q_dout;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  assign cfg_ready = 1'b1;

  cpd_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD),
    .AW(AW)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .in_rx_byte(in_rx_byte),
    .full(full),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .q_full(q_full),
    .q_empty(q_empty),
    .q_push(q_push),
    .q_cmd(q_din),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  cpd_cmdq u_cmdq (
    .clk(clk),
    .rst_n(rst_n),
    .push(q_push),
    .din(q_din),
    .pop(q_pop),
    .dout(q_dout),
    .full(q_full),
    .empty(q_empty)
  );

  cpd_back #(
    .MAX_PAYLOAD(MAX_PAYLOAD),
    .AW(AW)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .cmd_valid(!q_empty),
    .cmd(q_dout),
    .cmd_pop(q_pop),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .pop(pop),
    .empty(empty),
    .out_kind(out_kind),
    .out_msg_id(out_msg_id),
    .out_length(out_length),
    .out_data_byte(out_data_byte),
    .out_has_data(out_has_data),
    .out_last(out_last),
    .out_fault_code(out_fault_code)
  );

endmodule
`default_nettype wire

// ===== tb/cpd_tb_pkg.sv =====
// Register indexes, result record and CRC-16/XMODEM helper for the deframer testbench.
`timescale 1ns / 1ps
package cpd_tb_pkg;
  import cpd_pkg::*;

  localparam logic [7:0] REG_MAGIC_FIRST  = 8'd0;
  localparam logic [7:0] REG_MAGIC_SECOND = 8'd1;
  localparam logic [7:0] REG_MAX_LEN      = 8'd2;
  localparam logic [7:0] REG_THRESHOLD    = 8'd3;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       msg_id;
    logic [LEN_W-1:0] length;
    logic [7:0]       data_byte;
    logic             has_data;
    logic             last;
    logic [1:0]       fault_code;
  } deframe_result_t;

  // Bit-serial form, MSB of the byte first.
  function automatic logic [15:0] crc16_xmodem_next(input logic [15:0] crc,
                                                    input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0};
      if (fb) c = c ^ 16'h1021;
    end
    return c;
  endfunction

endpackage

// ===== tb/crc_checked_packet_deframer_checker.sv =====
// Deframer checker: watches all channels, predicts results per accepted byte and compares.
`timescale 1ns / 1ps
module crc_checked_packet_deframer_checker
  import cpd_pkg::*;
  import cpd_tb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic             full,
  input  logic [7:0]       in_rx_byte,
  input  logic             empty,
  input  logic             pop,
  input  logic [1:0]       out_kind,
  input  logic [7:0]       out_msg_id,
  input  logic [LEN_W-1:0] out_length,
  input  logic [7:0]       out_data_byte,
  input  logic             out_has_data,
  input  logic             out_last,
  input  logic [1:0]       out_fault_code,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [7:0]       cfg_index,
  input  logic [7:0]       cfg_data,
  output int               fail_count,
  output int               pending,
  output int               n_data,
  output int               n_fault,
  output int               n_fatal
);

  typedef enum logic [2:0] {
    WAIT_MAGIC1, WAIT_MAGIC2, TAKE_ID, TAKE_LEN, TAKE_PAYLOAD, TAKE_CRC_LO, TAKE_CRC_HI
  } parse_phase_e;

  logic [7:0]       magic1_reg;
  logic [7:0]       magic2_reg;
  logic [5:0]       max_len_reg;
  logic [7:0]       threshold_reg;

  parse_phase_e     phase;
  logic [7:0]       frame_id;
  logic [5:0]       frame_len;
  logic [5:0]       byte_idx;
  logic [7:0]       payload [0:63];
  logic [15:0]      rx_crc;
  logic [7:0]       fault_cnt;
  logic             synced;
  logic             halted;

  deframe_result_t  expected_results[$];
  int               fails = 0;
  int               data_cnt = 0;
  int               fault_res_cnt = 0;
  int               fatal_cnt = 0;

  task automatic reset_model();
    magic1_reg = 8'hAA;
    magic2_reg = 8'h55;
    max_len_reg = 6'd32;
    threshold_reg = 8'd8;
    phase = WAIT_MAGIC1;
    frame_id = 8'h00;
    frame_len = 6'd0;
    byte_idx = 6'd0;
    rx_crc = 16'h0000;
    fault_cnt = 8'h00;
    synced = 1'b0;
    halted = 1'b0;
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] deframer mismatch: %s", $time, msg);
    fails++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  task automatic note_fault(input logic [1:0] code);
    deframe_result_t r;
    if (!synced) return;
    if (fault_cnt != 8'hFF) fault_cnt = fault_cnt + 8'd1;
    r = '0;
    r.last = 1'b1;
    r.fault_code = code;
    if (threshold_reg != 8'd0 && fault_cnt >= threshold_reg) begin
      halted = 1'b1;
      r.kind = KIND_FATAL;
    end else begin
      r.kind = KIND_FAULT;
    end
    expected_results.push_back(r);
  endtask

  task automatic close_frame();
    deframe_result_t r;
    logic [15:0]     crc;
    crc = 16'h0000;
    crc = crc16_xmodem_next(crc, magic1_reg);
    crc = crc16_xmodem_next(crc, magic2_reg);
    crc = crc16_xmodem_next(crc, frame_id);
    crc = crc16_xmodem_next(crc, {2'b00, frame_len});
    for (int i = 0; i < frame_len; i++) crc = crc16_xmodem_next(crc, payload[i]);
    if (crc != rx_crc) begin
      note_fault(FAULT_CRC);
      return;
    end
    fault_cnt = 8'h00;
    synced = 1'b1;
    if (frame_len == 6'd0) begin
      r = '0;
      r.kind = KIND_DATA;
      r.msg_id = frame_id;
      r.last = 1'b1;
      expected_results.push_back(r);
    end else begin
      for (int i = 0; i < frame_len; i++) begin
        r = '0;
        r.kind = KIND_DATA;
        r.msg_id = frame_id;
        r.length = frame_len;
        r.data_byte = payload[i];
        r.has_data = 1'b1;
        r.last = (i == frame_len - 1);
        expected_results.push_back(r);
      end
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    if (halted) return;
    case (phase)
      WAIT_MAGIC1: begin
        if (b == magic1_reg) phase = WAIT_MAGIC2;
        else note_fault(FAULT_MAGIC1);
      end
      WAIT_MAGIC2: begin
        if (b == magic2_reg) begin
          phase = TAKE_ID;
        end else begin
          note_fault(FAULT_MAGIC2);
          phase = WAIT_MAGIC1;
        end
      end
      TAKE_ID: begin
        frame_id = b;
        phase = TAKE_LEN;
      end
      TAKE_LEN: begin
        byte_idx = 6'd0;
        frame_len = b[5:0];
        if (b > max_len_reg || b > MAX_PAYLOAD_DEF) begin
          note_fault(FAULT_LEN);
          phase = WAIT_MAGIC1;
        end else begin
          phase = (b != 8'd0) ? TAKE_PAYLOAD : TAKE_CRC_LO;
        end
      end
      TAKE_PAYLOAD: begin
        payload[byte_idx] = b;
        byte_idx = byte_idx + 6'd1;
        if (byte_idx >= frame_len) phase = TAKE_CRC_LO;
      end
      TAKE_CRC_LO: begin
        rx_crc = {8'h00, b};
        phase = TAKE_CRC_HI;
      end
      TAKE_CRC_HI: begin
        rx_crc[15:8] = b;
        close_frame();
        phase = WAIT_MAGIC1;
      end
      default: phase = WAIT_MAGIC1;
    endcase
  endtask

  always @(posedge clk) begin : watch
    deframe_result_t want;
    if (!rst_n) begin
      reset_model();
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAGIC_FIRST:  magic1_reg = cfg_data;
          REG_MAGIC_SECOND: magic2_reg = cfg_data;
          REG_MAX_LEN:      max_len_reg = cfg_data[5:0];
          REG_THRESHOLD:    threshold_reg = cfg_data;
          default: ;
        endcase
      end
      if (push && !full) deframe_byte(in_rx_byte);
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d code %0d data 0x%0h",
                                    out_kind, out_fault_code, out_data_byte));
        end else begin
          want = expected_results.pop_front();
          check_field("kind", out_kind, want.kind);
          check_field("msg_id", out_msg_id, want.msg_id);
          check_field("length", out_length, want.length);
          check_field("data_byte", out_data_byte, want.data_byte);
          check_field("has_data", out_has_data, want.has_data);
          check_field("last", out_last, want.last);
          check_field("fault_code", out_fault_code, want.fault_code);
          if (want.kind == KIND_DATA) data_cnt++;
          else if (want.kind == KIND_FAULT) fault_res_cnt++;
          else fatal_cnt++;
        end
      end
    end
    pending <= expected_results.size();
    fail_count <= fails;
    n_data <= data_cnt;
    n_fault <= fault_res_cnt;
    n_fatal <= fatal_cnt;
  end

endmodule

// ===== tb/tb_crc_checked_packet_deframer.sv =====
// Testbench top for the packet deframer: clock, reset, byte and config stimulus, verdict.
`timescale 1ns / 1ps
module tb_crc_checked_packet_deframer;
  import cpd_pkg::*;
  import cpd_tb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             push = 1'b0;
  logic [7:0]       in_rx_byte = 8'h00;
  logic             pop = 1'b0;
  logic             cfg_valid = 1'b0;
  logic [7:0]       cfg_index = REG_MAGIC_FIRST;
  logic [7:0]       cfg_data = 8'h00;

  logic             full;
  logic             empty;
  logic [1:0]       out_kind;
  logic [7:0]       out_msg_id;
  logic [LEN_W-1:0] out_length;
  logic [7:0]       out_data_byte;
  logic             out_has_data;
  logic             out_last;
  logic [1:0]       out_fault_code;
  logic             cfg_ready;

  int               fail_count;
  int               pending;
  int               n_data;
  int               n_fault;
  int               n_fatal;

  logic [7:0]       cur_magic1 = 8'hAA;
  logic [7:0]       cur_magic2 = 8'h55;
  logic [5:0]       cur_max_len = 6'd32;
  logic [7:0]       cur_threshold = 8'd8;

  int               cycles = 0;
  int               bytes_sent = 0;
  int               faults_in_row = 0;
  int               stall_left = 0;
  bit               quiet_in = 1'b0;
  bit               quiet_out = 1'b0;

  crc_checked_packet_deframer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_rx_byte     (in_rx_byte),
    .empty          (empty),
    .pop            (pop),
    .out_kind       (out_kind),
    .out_msg_id     (out_msg_id),
    .out_length     (out_length),
    .out_data_byte  (out_data_byte),
    .out_has_data   (out_has_data),
    .out_last       (out_last),
    .out_fault_code (out_fault_code),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  crc_checked_packet_deframer_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_rx_byte     (in_rx_byte),
    .empty          (empty),
    .pop            (pop),
    .out_kind       (out_kind),
    .out_msg_id     (out_msg_id),
    .out_length     (out_length),
    .out_data_byte  (out_data_byte),
    .out_has_data   (out_has_data),
    .out_last       (out_last),
    .out_fault_code (out_fault_code),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (pending),
    .n_data         (n_data),
    .n_fault        (n_fault),
    .n_fatal        (n_fatal)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[crc_checked_packet_deframer] ERROR");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(25, 70);
  endfunction

  function automatic logic [7:0] other_than(input logic [7:0] v);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == v) b = ~v;
    return b;
  endfunction

  function automatic logic [5:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 6'($urandom_range(0, (cur_max_len < 6) ? cur_max_len : 6));
    if (r < 90) return 6'($urandom_range(0, cur_max_len));
    return cur_max_len;
  endfunction

  always @(posedge clk) begin
    if (cycles % 256 == 0) quiet_out <= ($urandom_range(0, 2) == 0);
    if (!rst_n) begin
      pop <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      pop <= 1'b1;
      if (!quiet_out && $urandom_range(0, 99) < 25) stall_left <= gap_len();
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (!quiet_in && $urandom_range(0, 99) < 30) gap = gap_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] id, input logic [5:0] len, input bit bad_crc);
    logic [7:0]  body [0:31];
    logic [15:0] crc;
    crc = 16'h0000;
    crc = crc16_xmodem_next(crc, cur_magic1);
    crc = crc16_xmodem_next(crc, cur_magic2);
    crc = crc16_xmodem_next(crc, id);
    crc = crc16_xmodem_next(crc, {2'b00, len});
    for (int i = 0; i < len; i++) begin
      body[i] = 8'($urandom_range(0, 255));
      crc = crc16_xmodem_next(crc, body[i]);
    end
    if (bad_crc) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
    send_byte(cur_magic1);
    send_byte(cur_magic2);
    send_byte(id);
    send_byte({2'b00, len});
    for (int i = 0; i < len; i++) send_byte(body[i]);
    send_byte(crc[7:0]);
    send_byte(crc[15:8]);
  endtask

  // Broken sequences end cleanly so the parser is back at the first magic.
  task automatic send_broken();
    case ($urandom_range(0, 3))
      0: send_byte(other_than(cur_magic1));
      1: begin
        send_byte(cur_magic1);
        send_byte(other_than(cur_magic2));
      end
      2: begin
        send_byte(cur_magic1);
        send_byte(cur_magic2);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(int'(cur_max_len) + 1, 255)));
      end
      default: send_frame(8'($urandom_range(0, 255)), pick_len(), 1'b1);
    endcase
  endtask

  // Keep the run of faults below the threshold so the halt only comes at the end.
  task automatic random_traffic(input int n, input bit faults_ok);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < n) begin
      if ($urandom_range(0, 19) == 0) quiet_in = ~quiet_in;
      if (faults_ok && faults_in_row < int'(cur_threshold) - 2 &&
          $urandom_range(0, 99) < 20) begin
        send_broken();
        faults_in_row++;
      end else begin
        send_frame(8'($urandom_range(0, 255)), pick_len(), 1'b0);
        faults_in_row = 0;
      end
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic put_reg(input logic [7:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_config(input logic [7:0] m1, input logic [7:0] m2,
                              input logic [5:0] ml, input logic [7:0] thr);
    put_reg(REG_MAGIC_FIRST, m1);
    put_reg(REG_MAGIC_SECOND, m2);
    put_reg(REG_MAX_LEN, {2'b00, ml});
    put_reg(REG_THRESHOLD, thr);
    cfg_valid <= 1'b0;
    cur_magic1 = m1;
    cur_magic2 = m2;
    cur_max_len = ml;
    cur_threshold = thr;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // unsynced faults stay silent
    send_byte(8'h00);
    send_byte(8'hAA);
    send_byte(8'h11);
    send_frame(8'hFF, 6'd0, 1'b0);
    // bad second magic, then its byte is not retried as a first magic
    send_byte(8'hAA);
    send_byte(8'hAA);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(8'h55);
    send_byte(8'h00);
    send_byte(8'(MAX_PAYLOAD_DEF + 1));
    send_frame(8'h00, 6'd0, 1'b1);
    send_frame(8'h80, 6'd1, 1'b0);
    faults_in_row = 0;

    random_traffic(60, 1'b1);
    drain();

    write_config(8'h00, 8'hFF, 6'd0, 8'd255);
    random_traffic(25, 1'b1);
    drain();

    write_config(8'hFF, 8'h00, 6'd32, 8'd1);
    random_traffic(45, 1'b0);
    drain();

    write_config(8'h5A, 8'h5A, 6'd17, 8'd6);
    random_traffic(35, 1'b1);
    drain();
    random_traffic(35, 1'b1);
    drain();

    // zero threshold never halts; a later threshold above the count trips once further faults reach it
    write_config(8'hAA, 8'h55, 6'd32, 8'd0);
    repeat (12) send_byte(other_than(cur_magic1));
    drain();
    write_config(8'hAA, 8'h55, 6'd32, 8'd20);
    repeat (12) send_byte(other_than(cur_magic1));
    repeat (6) send_byte(8'($urandom_range(0, 255)));
    drain();

    $display("deframer run: %0d bytes sent, %0d data, %0d fault and %0d fatal results checked",
             bytes_sent, n_data, n_fault, n_fatal);
    $display("settings: reset values, zero max length, threshold one, equal magic bytes, %s",
             "faults past a zero threshold, then halt");
    if (fail_count == 0 && pending == 0) begin
      $display("[crc_checked_packet_deframer] OK");
    end else begin
      $display("[crc_checked_packet_deframer] ERROR");
    end
    $finish;
  end

endmodule

// ===== crc_checked_packet_deframer.f =====
design/cpd_pkg.sv
design/cpd_front.sv
design/cpd_cmdq.sv
design/cpd_back.sv
design/crc_checked_packet_deframer.sv
tb/cpd_tb_pkg.sv
tb/crc_checked_packet_deframer_checker.sv
tb/tb_crc_checked_packet_deframer.sv
